// ----- src/nstep_sarsa_qtable_update_assert.svh -----
// Assertion helpers, clocked on clk, disabled in rst.
`ifndef NSTEP_SARSA_QTABLE_UPDATE_ASSERT_SVH
`define NSTEP_SARSA_QTABLE_UPDATE_ASSERT_SVH
// same-cycle implication
`define NSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define NSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/nsq_pkg.sv -----
package nsq_pkg;
  localparam int ST_W = 8;
  localparam int NUM_STATES = 1 << ST_W;
  localparam int HIST_DEPTH = 3;
  localparam logic [16:0] Q_ONE = 17'd65536;
  localparam logic [16:0] LEARN_RST = 17'd6554;
  localparam logic [16:0] DISC_RST = 17'd58982;
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic REG_LEARN = 1'b0;
  localparam logic REG_DISC = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_RD_CUR, S_CAP_CUR, S_RD_ENT, S_CAP_ENT,
    S_MUL1, S_MUL2, S_WRITE, S_RD_OUT, S_OUT
  } state_t;

  typedef enum logic [1:0] {ENT_CUR, ENT_MID, ENT_OLD} ent_t;

  typedef struct packed {
    logic push;
    logic rd_cur;
    logic cap_cur;
    logic rd_ent;
    logic cap_ent;
    logic mul1;
    logic mul2;
    logic wr;
    logic rd_out;
    logic out_load;
    logic pass;
    ent_t ent;
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic fin;
    logic full_next;
    logic out_busy;
  } stat_t;

  function automatic logic [16:0] cap_rate(input logic [16:0] r);
    return (r > Q_ONE) ? Q_ONE : r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    if (v > 39'sd2147483647) return 32'sh7fffffff;
    else if (v < -39'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage

// ----- src/nsq_ctrl.sv -----
module nsq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nsq_pkg::stat_t st,
  output nsq_pkg::cmd_t  cmd
);
  import nsq_pkg::*;

  state_t state, state_next;
  logic pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass <= 1'b0;
    end else begin
      state <= state_next;
      pass <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    pass_next = pass;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_PUSH;
      S_PUSH: begin
        pass_next = 1'b0;
        if (st.clear) state_next = S_RD_OUT;
        else if (st.fin) state_next = S_RD_ENT;
        else if (st.full_next) state_next = S_RD_CUR;
        else state_next = S_RD_OUT;
      end
      S_RD_CUR:  state_next = S_CAP_CUR;
      S_CAP_CUR: state_next = S_RD_ENT;
      S_RD_ENT:  state_next = S_CAP_ENT;
      S_CAP_ENT: state_next = S_MUL1;
      S_MUL1:    state_next = S_MUL2;
      S_MUL2:    state_next = S_WRITE;
      S_WRITE: begin
        pass_next = 1'b1;
        state_next = (!pass && !st.fin) ? S_RD_ENT : S_RD_OUT;
      end
      S_RD_OUT:  state_next = S_OUT;
      S_OUT:     if (!st.out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.pass = pass;
    cmd.ent = st.fin ? ENT_CUR : (pass ? ENT_OLD : ENT_MID);
    in_ready = 1'b0;
    unique case (state)
      S_IDLE:    in_ready = 1'b1;
      S_PUSH:    cmd.push = 1'b1;
      S_RD_CUR:  cmd.rd_cur = 1'b1;
      S_CAP_CUR: cmd.cap_cur = 1'b1;
      S_RD_ENT:  cmd.rd_ent = 1'b1;
      S_CAP_ENT: cmd.cap_ent = 1'b1;
      S_MUL1:    cmd.mul1 = 1'b1;
      S_MUL2:    cmd.mul2 = 1'b1;
      S_WRITE:   cmd.wr = 1'b1;
      S_RD_OUT:  cmd.rd_out = 1'b1;
      S_OUT:     cmd.out_load = !st.out_busy;
      default:   ;
    endcase
  end

  `include "nstep_sarsa_qtable_update_assert.svh"
  `NSQ_ASSERT_NEXT(a_second_pass, (state == S_WRITE) && !pass && !st.fin, state == S_RD_ENT, "second update pass skipped")
  `NSQ_ASSERT_NEXT(a_clear_short, (state == S_PUSH) && st.clear, state == S_RD_OUT, "clear touched the tables")
  `NSQ_ASSERT_NOW(a_cap_after_rd, state == S_CAP_ENT, $past(state) == S_RD_ENT, "capture without read")
endmodule

// ----- src/nsq_dp.sv -----
module nsq_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               cmd_in,
  input  logic [7:0]         state_index,
  input  logic               action,
  input  logic signed [31:0] reward,
  input  logic               is_final,
  input  logic [16:0]        learn_rate,
  input  logic [16:0]        discount_rate,
  input  nsq_pkg::cmd_t      cmd,
  output nsq_pkg::stat_t     st,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               policy_changed,
  output logic               greedy_action
);
  import nsq_pkg::*;

  // item registers
  logic               it_clear, it_a, it_fin;
  logic [ST_W-1:0]    it_s;
  logic signed [31:0] it_r;

  // history
  logic [ST_W-1:0] hist_s [HIST_DEPTH];
  logic            hist_a [HIST_DEPTH];
  logic [1:0]      fill;
  logic            changed;

  // tables: row = {Q jump, Q noop}, valid bits stand for zero reset
  // (both tables are written together, so one valid bit covers a row of each)
  logic [63:0]           q_mem [NUM_STATES];
  logic                  g_mem [NUM_STATES];
  logic [NUM_STATES-1:0] q_vld;
  logic [63:0]           rd_row;
  logic                  rd_qv, rd_g;

  logic [ST_W-1:0]    ent_s, rd_addr;
  logic               ent_a;
  logic signed [31:0] qn, qold, qoth, newq;
  logic               gold, gnew;
  logic [16:0]        g1, g2, gsel, alpha;
  logic [33:0]        g2w;
  logic signed [49:0] pg;
  logic signed [34:0] tgt;
  logic signed [35:0] diff;
  logic signed [53:0] pa;
  logic signed [38:0] sum;
  logic [63:0]        row_val;
  logic signed [31:0] q0n, q1n;

  always_ff @(posedge clk) begin
    if (accept) begin
      it_clear <= (cmd_in == CMD_CLEAR);
      it_s <= state_index[ST_W-1:0];
      it_a <= action;
      it_r <= reward;
      it_fin <= is_final;
    end
  end

  assign st.clear = it_clear;
  assign st.fin = it_fin;
  assign st.full_next = (fill == 2'd2) || (fill == 2'd3);
  assign st.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (cmd.push) begin
      if (it_clear) fill <= 2'd0;
      else if (fill != 2'd3) fill <= fill + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !it_clear) begin
      if (fill == 2'd3) begin
        hist_s[0] <= hist_s[1];
        hist_a[0] <= hist_a[1];
        hist_s[1] <= hist_s[2];
        hist_a[1] <= hist_a[2];
        hist_s[2] <= it_s;
        hist_a[2] <= it_a;
      end else begin
        hist_s[fill] <= it_s;
        hist_a[fill] <= it_a;
      end
    end
  end

  // gamma powers
  assign g1 = cap_rate(discount_rate);
  assign alpha = cap_rate(learn_rate);
  assign g2w = 34'(g1) * 34'(g1);
  always_ff @(posedge clk) begin
    if (cmd.push) g2 <= g2w[32:16];
  end
  assign gsel = cmd.pass ? g2 : g1;

  always_comb begin
    case (cmd.ent)
      ENT_MID: rd_addr = hist_s[1];
      ENT_OLD: rd_addr = hist_s[0];
      default: rd_addr = it_s;
    endcase
    if (cmd.rd_cur || cmd.rd_out) rd_addr = it_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_ent) begin
      ent_s <= rd_addr;
      case (cmd.ent)
        ENT_MID: ent_a <= hist_a[1];
        ENT_OLD: ent_a <= hist_a[0];
        default: ent_a <= it_a;
      endcase
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      q_mem[ent_s] <= ent_a ? {newq, qoth} : {qoth, newq};
      g_mem[ent_s] <= gnew;
    end
    if (cmd.rd_cur || cmd.rd_ent || cmd.rd_out) begin
      rd_row <= q_mem[rd_addr];
      rd_g <= g_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= '0;
    end else if (cmd.wr) begin
      q_vld[ent_s] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_cur || cmd.rd_ent || cmd.rd_out) begin
      rd_qv <= q_vld[rd_addr];
    end
  end

  assign row_val = rd_qv ? rd_row : 64'd0;

  // update arithmetic
  assign tgt = 35'(it_r) + (it_fin ? 35'sd0 : 35'($signed(pg[49:16])));
  assign diff = 36'(tgt) - 36'(qold);
  assign sum = 39'(qold) + 39'($signed(pa[53:16]));
  assign newq = sat32(sum);
  assign q0n = ent_a ? qoth : newq;
  assign q1n = ent_a ? newq : qoth;
  assign gnew = (q0n > q1n) ? 1'b0 : 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.cap_cur) qn <= it_a ? row_val[63:32] : row_val[31:0];
    if (cmd.cap_ent) begin
      qold <= ent_a ? row_val[63:32] : row_val[31:0];
      qoth <= ent_a ? row_val[31:0] : row_val[63:32];
      gold <= rd_qv & rd_g;
    end
    if (cmd.mul1) pg <= $signed({1'b0, gsel}) * qn;
    if (cmd.mul2) pa <= $signed({1'b0, alpha}) * diff;
    if (cmd.wr) qn <= newq;
  end

  always_ff @(posedge clk) begin
    if (rst) changed <= 1'b0;
    else if (cmd.push && it_clear) changed <= 1'b0;
    else if (cmd.wr) changed <= (gold != gnew);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      policy_changed <= changed;
      greedy_action <= rd_qv & rd_g;
    end
  end
endmodule

// ----- src/nstep_sarsa_qtable_update.sv -----
// Two-step SARSA Q-table update, one result item per input item.
// Clear and short-history steps just read the current row for the result; a final
// step makes one read-modify-write pass on the Q row memory, a full-history step
// reads the current row, then two chained passes (read, capture, gamma multiply,
// alpha multiply, write). in_ready returns in the cycle that out_valid rises.
// Reset (rst, synchronous): tables read as zero / noop through per-row valid bits,
// history empty, changed flag 0, learn_rate 6554, discount_rate 58982.
module nstep_sarsa_qtable_update (
  input  logic               clk,
  input  logic               rst,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // step items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [7:0]         state_index,
  input  logic               action,
  input  logic signed [31:0] reward,
  input  logic               is_final,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic               policy_changed,
  output logic               greedy_action
);
  import nsq_pkg::*;

  logic [16:0] learn_rate, discount_rate;
  cmd_t  dcmd;
  stat_t st;

  assign pready = 1'b1;

  // register file: word index from paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LEARN_RST;
      discount_rate <= DISC_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_LEARN: learn_rate <= pwdata[16:0];
        REG_DISC:  discount_rate <= pwdata[16:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LEARN: prdata = {15'd0, learn_rate};
      REG_DISC:  prdata = {15'd0, discount_rate};
      default:   prdata = 32'd0;
    endcase
  end

  nsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (dcmd)
  );

  nsq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_valid && in_ready),
    .cmd_in         (cmd),
    .state_index    (state_index),
    .action         (action),
    .reward         (reward),
    .is_final       (is_final),
    .learn_rate     (learn_rate),
    .discount_rate  (discount_rate),
    .cmd            (dcmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .policy_changed (policy_changed),
    .greedy_action  (greedy_action)
  );
endmodule
